// ===== sv/dsss_prn_despreader_byte_packer_defines.svh =====
// assertion macros for the despreader top file
`ifndef DSSS_PRN_DESPREADER_BYTE_PACKER_DEFINES_SVH
`define DSSS_PRN_DESPREADER_BYTE_PACKER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define DSSSDESP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dsssdesp same-cycle check failed");

// next-cycle implication, disabled while in reset
`define DSSSDESP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dsssdesp next-cycle check failed");

`endif

// ===== sv/dsssdesp_pkg.sv =====
package dsssdesp_pkg;

    localparam int DATA_CHIPS  = 512;
    localparam int POS_W       = 10;
    localparam int CNT_W       = 10;
    localparam int THR_W       = 10;
    localparam int JUNK_W      = 8;
    localparam int CHIP_W      = 8;
    localparam int BYTE_W      = 8;
    localparam int BITCNT_W    = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;
    localparam int ROM_IDX_W   = 9;

    localparam logic [THR_W-1:0]  THRESHOLD_RESET = 10'd409;
    localparam logic [JUNK_W-1:0] JUNK_RESET      = 8'd96;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_JUNK      = 2'd1;

    // code bit 0 sits in bit 31 of word 0
    localparam logic [31:0] CODE0_ROM [16] = '{
        32'h015ED461, 32'h0BF3315C, 32'h66925B2A, 32'hE0A300E1,
        32'hBB9F31CF, 32'hF7C0B275, 32'hAAA7A512, 32'h0F5B023D,
        32'h4E608E17, 32'h34856145, 32'h06A2362F, 32'hA91FEBFD,
        32'h9D481918, 32'hAF369300, 32'h1085281D, 32'h5CAF64DA
    };

    localparam logic [31:0] CODE1_ROM [16] = '{
        32'hFD3E77D5, 32'hFA7CEFAA, 32'hF4F9DF54, 32'hE9F3BEA9,
        32'hD3E77D52, 32'hA7CEFAA4, 32'h4F9DF549, 32'h9F3BEA92,
        32'h3E77D525, 32'h7CEFAA4B, 32'hF9DF5497, 32'hF3BEA92F,
        32'hE77D525E, 32'hCEFAA4BD, 32'h9DF5497B, 32'h3BEA92F7
    };

    typedef struct packed {
        logic first;     // item restarts the bit period and the packer
        logic bit_done;  // item was the last data chip of a bit
        logic bit_val;   // decided bit, meaningful with bit_done
    } corr_evt_t;

    function automatic logic code0_bit(input logic [ROM_IDX_W-1:0] pos);
        logic [31:0] word;
        word = CODE0_ROM[pos[8:5]];
        return word[~pos[4:0]];
    endfunction

    function automatic logic code1_bit(input logic [ROM_IDX_W-1:0] pos);
        logic [31:0] word;
        word = CODE1_ROM[pos[8:5]];
        return word[~pos[4:0]];
    endfunction

endpackage

// ===== sv/dsss_prn_despreader_byte_packer.sv =====
// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+------------------------------
// input     | in        | in_valid / in_ready   | chip[7:0], first_chip
// output    | out       | out_valid / out_ready | data_byte[7:0]
// config    | in        | cfg_valid / cfg_ready | cfg_index[1:0], cfg_data[9:0]
//
// one chip per cycle while not stalled; a chip is held in the input register
// and is processed from there at the edge that also loads a finished byte for output
// reset clears position, match counts, packer and both valid flags; threshold
// returns to 409 and junk count to 96
// an unread byte stalls the input only when the buffered chip would finish the
// next byte; every other chip keeps flowing at full rate
`include "dsss_prn_despreader_byte_packer_defines.svh"

module dsss_prn_despreader_byte_packer (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [dsssdesp_pkg::CHIP_W-1:0]       chip,
    input  logic                                  first_chip,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [dsssdesp_pkg::BYTE_W-1:0]       data_byte,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [dsssdesp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [dsssdesp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import dsssdesp_pkg::*;

    // configuration registers
    logic [THR_W-1:0]  threshold_reg;
    logic [JUNK_W-1:0] junk_reg;

    // input register
    logic              in_valid_reg;
    logic [CHIP_W-1:0] chip_reg;
    logic              first_reg;

    logic      advance;
    logic      byte_due;
    corr_evt_t evt;

    // writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            junk_reg      <= JUNK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_THRESHOLD: threshold_reg <= cfg_data[THR_W-1:0];
                REG_JUNK:      junk_reg      <= cfg_data[JUNK_W-1:0];
                default:       ;
            endcase
        end
    end

    // the buffered chip moves on unless it would finish a byte while the
    // previous byte is still unread
    assign advance  = in_valid_reg && (!byte_due || !out_valid || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            chip_reg  <= chip;
            first_reg <= first_chip;
        end
    end

    // per-chip compare, count and bit decision
    dsssdesp_corr u_corr (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .chip       (chip_reg),
        .first_chip (first_reg),
        .threshold  (threshold_reg),
        .junk       (junk_reg),
        .evt        (evt)
    );

    // msb-first bit packing and byte output register
    dsssdesp_pack u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .evt       (evt),
        .out_ready (out_ready),
        .byte_due  (byte_due),
        .out_valid (out_valid),
        .data_byte (data_byte)
    );

    // an accepted chip is held in the input register next cycle
    `DSSSDESP_ASSERT_NEXT(a_in_captured, in_valid && in_ready, in_valid_reg)
    // a buffered chip that is not processed stays buffered
    `DSSSDESP_ASSERT_NEXT(a_in_held, in_valid_reg && !advance, in_valid_reg)
    // no processing while an unread byte would be overwritten
    `DSSSDESP_ASSERT_NOW(a_no_overwrite, out_valid && !out_ready && byte_due, !advance)

endmodule

// ===== sv/dsssdesp_corr.sv =====
module dsssdesp_corr (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic [dsssdesp_pkg::CHIP_W-1:0] chip,
    input  logic                           first_chip,
    input  logic [dsssdesp_pkg::THR_W-1:0]  threshold,
    input  logic [dsssdesp_pkg::JUNK_W-1:0] junk,
    output dsssdesp_pkg::corr_evt_t        evt
);
    import dsssdesp_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next, pos_eff;
    logic [CNT_W-1:0] c0_reg, c0_next, c0_base, c0_inc;
    logic [CNT_W-1:0] c1_reg, c1_next, c1_base, c1_inc;
    logic [POS_W:0]   pos_inc, period;
    logic             in_data, last, m0, m1, bit_val;

    always_comb
    begin
        pos_eff = first_chip ? '0 : pos_reg;
        c0_base = first_chip ? '0 : c0_reg;
        c1_base = first_chip ? '0 : c1_reg;

        in_data = pos_eff < POS_W'(DATA_CHIPS);
        last    = pos_eff == POS_W'(DATA_CHIPS - 1);

        m0 = chip == {{(CHIP_W-1){1'b0}}, code0_bit(pos_eff[ROM_IDX_W-1:0])};
        m1 = chip == {{(CHIP_W-1){1'b0}}, code1_bit(pos_eff[ROM_IDX_W-1:0])};

        c0_inc = c0_base + CNT_W'(m0);
        c1_inc = c1_base + CNT_W'(m1);

        // code 0 wins ties; neither above threshold decides 0
        if (c0_inc > threshold)
        begin
            bit_val = 1'b0;
        end
        else
        begin
            bit_val = c1_inc > threshold;
        end

        if (last)
        begin
            c0_next = '0;
            c1_next = '0;
        end
        else if (in_data)
        begin
            c0_next = c0_inc;
            c1_next = c1_inc;
        end
        else
        begin
            c0_next = c0_base;
            c1_next = c1_base;
        end

        pos_inc  = {1'b0, pos_eff} + (POS_W+1)'(1);
        period   = (POS_W+1)'(DATA_CHIPS) + (POS_W+1)'(junk);
        pos_next = (pos_inc >= period) ? '0 : pos_inc[POS_W-1:0];

        evt.first    = first_chip;
        evt.bit_done = last;
        evt.bit_val  = bit_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            c0_reg  <= '0;
            c1_reg  <= '0;
        end
        else if (step)
        begin
            pos_reg <= pos_next;
            c0_reg  <= c0_next;
            c1_reg  <= c1_next;
        end
    end

endmodule

// ===== sv/dsssdesp_pack.sv =====
module dsssdesp_pack (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  dsssdesp_pkg::corr_evt_t         evt,
    input  logic                            out_ready,
    output logic                            byte_due,
    output logic                            out_valid,
    output logic [dsssdesp_pkg::BYTE_W-1:0] data_byte
);
    import dsssdesp_pkg::*;

    logic [BYTE_W-1:0]   sh_reg, sh_next, sh_eff, shifted;
    logic [BITCNT_W-1:0] cnt_reg, cnt_next, cnt_eff;
    logic [BYTE_W-1:0]   byte_reg;
    logic                valid_reg, valid_next, emit;

    always_comb
    begin
        sh_eff   = evt.first ? '0 : sh_reg;
        cnt_eff  = evt.first ? '0 : cnt_reg;
        shifted  = {sh_eff[BYTE_W-2:0], evt.bit_val};
        // current chip would complete a byte
        byte_due = evt.bit_done && (cnt_eff == {BITCNT_W{1'b1}});
        emit     = step && byte_due;
        sh_next  = sh_reg;
        cnt_next = cnt_reg;
        if (step)
        begin
            if (evt.bit_done)
            begin
                sh_next  = emit ? '0 : shifted;
                cnt_next = cnt_eff + BITCNT_W'(1);
            end
            else
            begin
                sh_next  = sh_eff;
                cnt_next = cnt_eff;
            end
        end
        valid_next = emit || (valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sh_reg    <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sh_reg    <= sh_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            byte_reg <= shifted;
        end
    end

    assign out_valid = valid_reg;
    assign data_byte = byte_reg;

endmodule
